@@ src/sclf_pkg.sv @@
// ----------------------------------------------------------------------------
// sclf_pkg
// Shared types, widths and helper functions for the line scale and clip block.
// ----------------------------------------------------------------------------
package sclf_pkg;

  localparam int GRID_LOG2 = 8;
  localparam int CW        = 14;
  localparam int SW        = 22;
  localparam int DW        = 23;
  localparam int PW        = 46;
  localparam int NW        = 47;
  localparam int QB        = 17;
  localparam int RW        = DW + QB;
  localparam int DIV_LAT   = QB + 1;
  localparam int QDEPTH    = 4;
  localparam int QPW       = $clog2(QDEPTH);

  localparam logic [CW-1:0] WIDTH_RESET  = CW'(1920);
  localparam logic [CW-1:0] HEIGHT_RESET = CW'(1080);
  localparam logic          REG_WIDTH    = 1'b0;
  localparam logic          REG_HEIGHT   = 1'b1;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
  } line_in_t;

  typedef struct packed {
    logic               segment_valid;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } seg_out_t;

  typedef struct packed {
    logic                  vert;
    logic                  dy_zero;
    logic signed [SW-1:0]  x1;
    logic signed [NW-1:0]  num0;
    logic signed [NW-1:0]  num1;
    logic signed [NW-1:0]  num2;
    logic signed [NW-1:0]  num3;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
  } work_t;

  typedef struct packed {
    logic                 vert;
    logic                 dy_zero;
    logic signed [SW-1:0] x1;
  } meta_t;

  typedef struct packed {
    logic          ovf;
    logic          neg;
    logic [QB-1:0] mag;
  } quot_t;

  function automatic logic signed [15:0] sat_scaled(input logic signed [SW-1:0] v);
    logic signed [15:0] r;
    if (v > SW'(32767)) r = 16'sh7fff;
    else if (v < SW'(-32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat_quot(input quot_t q);
    logic [15:0] m16;
    logic signed [15:0] r;
    m16 = {1'b0, q.mag[14:0]};
    if (!q.neg) r = (q.ovf || q.mag > QB'(32767)) ? 16'sh7fff : $signed(m16);
    else r = (q.ovf || q.mag >= QB'(32768)) ? 16'sh8000 : $signed(16'd0 - m16);
    return r;
  endfunction

  function automatic logic quot_in(input quot_t q, input logic signed [15:0] lim);
    return !q.ovf && !(q.neg && q.mag != '0) && !lim[15] && (q.mag <= QB'(lim[14:0]));
  endfunction

endpackage

@@ src/sclf_front.sv @@
// ----------------------------------------------------------------------------
// sclf_front
// Scales line points to the frame and forms the edge-cut numerators.
// ----------------------------------------------------------------------------
module sclf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  sclf_pkg::line_in_t     in_data,
  input  logic [sclf_pkg::CW-1:0] frame_width,
  input  logic [sclf_pkg::CW-1:0] frame_height,
  output logic                   out_valid,
  output sclf_pkg::work_t        out_data
);
  import sclf_pkg::*;

  function automatic logic signed [SW-1:0] grid_trunc(input logic signed [30:0] p);
    logic signed [30:0] pt;
    pt = p + (p[30] ? ((31'sd1 <<< GRID_LOG2) - 31'sd1) : 31'sd0);
    return SW'(pt >>> GRID_LOG2);
  endfunction

  logic [4:0] vld_r;

  logic signed [15:0] wsx, hsx;
  logic signed [15:0] lim_w, lim_h;
  assign wsx   = $signed({2'b00, frame_width});
  assign hsx   = $signed({2'b00, frame_height});
  assign lim_w = wsx - 16'sd1;
  assign lim_h = hsx - 16'sd1;

  // stage 1: products with frame size
  logic signed [30:0] px1_r, py1_r, px2_r, py2_r;
  // stage 2: scaled points
  logic signed [SW-1:0] x1_r, y1_r, x2_r, y2_r;
  // stage 3: differences and edge offsets
  logic signed [SW-1:0] x1_3_r, y1_3_r;
  logic signed [DW-1:0] dx_r, dy_r, a1_r, a2_r, b1_r, b2_r;
  logic                 vert_3_r;
  // stage 4: products
  logic signed [PW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [SW-1:0] x1_4_r;
  logic signed [DW-1:0] dx_4_r, dy_4_r;
  logic                 vert_4_r;
  // stage 5
  work_t work_r, work_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    px1_r <= 31'(in_data.first_x)  * 31'(wsx);
    py1_r <= 31'(in_data.first_y)  * 31'(hsx);
    px2_r <= 31'(in_data.second_x) * 31'(wsx);
    py2_r <= 31'(in_data.second_y) * 31'(hsx);

    x1_r <= grid_trunc(px1_r);
    y1_r <= grid_trunc(py1_r);
    x2_r <= grid_trunc(px2_r);
    y2_r <= grid_trunc(py2_r);

    x1_3_r   <= x1_r;
    y1_3_r   <= y1_r;
    vert_3_r <= (x1_r == x2_r);
    dx_r     <= DW'(x2_r) - DW'(x1_r);
    dy_r     <= DW'(y2_r) - DW'(y1_r);
    a1_r     <= DW'(1) - DW'(x1_r);
    a2_r     <= DW'(lim_w) - DW'(x1_r);
    b1_r     <= DW'(1) - DW'(y1_r);
    b2_r     <= DW'(lim_h) - DW'(y1_r);

    m0_r     <= PW'(dy_r) * PW'(a1_r);
    m1_r     <= PW'(y1_3_r) * PW'(dx_r);
    m2_r     <= PW'(dy_r) * PW'(a2_r);
    m3_r     <= PW'(dx_r) * PW'(b1_r);
    m4_r     <= PW'(x1_3_r) * PW'(dy_r);
    m5_r     <= PW'(dx_r) * PW'(b2_r);
    x1_4_r   <= x1_3_r;
    dx_4_r   <= dx_r;
    dy_4_r   <= dy_r;
    vert_4_r <= vert_3_r;

    work_r <= work_nxt;
  end

  always_comb begin
    work_nxt.vert    = vert_4_r;
    work_nxt.dy_zero = (dy_4_r == '0);
    work_nxt.x1      = x1_4_r;
    work_nxt.num0    = NW'(m0_r) + NW'(m1_r);
    work_nxt.num1    = NW'(m2_r) + NW'(m1_r);
    work_nxt.num2    = NW'(m3_r) + NW'(m4_r);
    work_nxt.num3    = NW'(m5_r) + NW'(m4_r);
    work_nxt.dx      = dx_4_r;
    work_nxt.dy      = dy_4_r;
  end

  assign out_valid = vld_r[4];
  assign out_data  = work_r;

endmodule

@@ src/sclf_queue.sv @@
// ----------------------------------------------------------------------------
// sclf_queue
// Short queue between the front and back sections.
// ----------------------------------------------------------------------------
module sclf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sclf_pkg::work_t push_data,
  input  logic            pop,
  output logic            deq_valid,
  output sclf_pkg::work_t deq_data,
  output logic            full
);
  import sclf_pkg::*;

  work_t            mem_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPW:0]     count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign deq_valid = (count_r != '0);
  assign deq_data  = mem_r[rd_ptr_r];
  assign full      = (count_r == (QPW+1)'(QDEPTH));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> deq_valid)
    else $error("queue underflow");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count mismatch");
`endif

endmodule

@@ src/sclf_div.sv @@
// ----------------------------------------------------------------------------
// sclf_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
// ----------------------------------------------------------------------------
module sclf_div (
  input  logic                            clk,
  input  logic signed [sclf_pkg::NW-1:0]  num,
  input  logic signed [sclf_pkg::DW-1:0]  den,
  output sclf_pkg::quot_t                 quot
);
  import sclf_pkg::*;

  logic [NW-1:0] an;
  logic [DW-1:0] ad;
  assign an = num[NW-1] ? NW'(-num) : NW'(num);
  assign ad = den[DW-1] ? DW'(-den) : DW'(den);

  logic [RW-1:0] rem_r [QB+1];
  logic [DW-1:0] ad_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= an[RW-1:0];
    ad_r[0]  <= ad;
    q_r[0]   <= '0;
    neg_r[0] <= num[NW-1] ^ den[DW-1];
    ovf_r[0] <= (an >= NW'({ad, {QB{1'b0}}}));
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0] sh;
    assign sh = RW'(ad_r[k]) << BIT;
    always_ff @(posedge clk) begin
      ad_r[k+1]  <= ad_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
      if (rem_r[k] >= sh) begin
        rem_r[k+1]    <= rem_r[k] - sh;
        q_r[k+1]      <= q_r[k] | (QB'(1) << BIT);
      end else begin
        rem_r[k+1]    <= rem_r[k];
        q_r[k+1]      <= q_r[k];
      end
    end
  end

  assign quot.ovf = ovf_r[QB];
  assign quot.neg = neg_r[QB];
  assign quot.mag = q_r[QB];

endmodule

@@ src/sclf_back.sv @@
// ----------------------------------------------------------------------------
// sclf_back
// Divides the edge cuts, tests them against the frame and picks the segment.
// ----------------------------------------------------------------------------
module sclf_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  sclf_pkg::work_t         in_data,
  input  logic [sclf_pkg::CW-1:0] frame_width,
  input  logic [sclf_pkg::CW-1:0] frame_height,
  output logic                    out_strobe,
  output sclf_pkg::seg_out_t      out_data
);
  import sclf_pkg::*;

  logic signed [15:0] lim_w, lim_h, h_m2;
  assign lim_w = $signed({2'b00, frame_width}) - 16'sd1;
  assign lim_h = $signed({2'b00, frame_height}) - 16'sd1;
  assign h_m2  = $signed({2'b00, frame_height}) - 16'sd2;

  quot_t q0, q1, q2, q3;
  sclf_div u_div0 (.clk(clk), .num(in_data.num0), .den(in_data.dx), .quot(q0));
  sclf_div u_div1 (.clk(clk), .num(in_data.num1), .den(in_data.dx), .quot(q1));
  sclf_div u_div2 (.clk(clk), .num(in_data.num2), .den(in_data.dy), .quot(q2));
  sclf_div u_div3 (.clk(clk), .num(in_data.num3), .den(in_data.dy), .quot(q3));

  logic  vld_r  [DIV_LAT];
  meta_t meta_r [DIV_LAT];

  always_ff @(posedge clk) begin
    meta_r[0] <= '{vert: in_data.vert, dy_zero: in_data.dy_zero, x1: in_data.x1};
    for (int i = 1; i < DIV_LAT; i++) meta_r[i] <= meta_r[i-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DIV_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // evaluation stage
  meta_t               mt;
  logic                ev_vld_r;
  logic [3:0]          hit_r;
  logic signed [15:0]  s_r [4];
  logic                vert_r, vert_ok_r;
  logic signed [15:0]  xs_r;

  assign mt = meta_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) ev_vld_r <= 1'b0;
    else        ev_vld_r <= vld_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    hit_r[0]  <= quot_in(q0, lim_h);
    hit_r[1]  <= quot_in(q1, lim_h);
    hit_r[2]  <= quot_in(q2, lim_w) && !mt.dy_zero;
    hit_r[3]  <= quot_in(q3, lim_w) && !mt.dy_zero;
    s_r[0]    <= sat_quot(q0);
    s_r[1]    <= sat_quot(q1);
    s_r[2]    <= sat_quot(q2);
    s_r[3]    <= sat_quot(q3);
    vert_r    <= mt.vert;
    vert_ok_r <= !mt.x1[SW-1] && (mt.x1 <= SW'(lim_w));
    xs_r      <= sat_scaled(mt.x1);
  end

  // selection stage
  seg_out_t           seg_nxt, seg_r;
  logic               strobe_r;
  logic signed [15:0] cx [4];
  logic signed [15:0] cy [4];

  always_comb begin
    logic [2:0]         n;
    logic signed [15:0] ax, ay, bx, by;
    cx[0] = 16'sd1;  cy[0] = s_r[0];
    cx[1] = lim_w;   cy[1] = s_r[1];
    cx[2] = s_r[2];  cy[2] = 16'sd1;
    cx[3] = s_r[3];  cy[3] = lim_h;
    n  = '0;
    ax = '0; ay = '0; bx = '0; by = '0;
    for (int i = 0; i < 4; i++) begin
      if (hit_r[i]) begin
        if (n == 3'd0) begin
          ax = cx[i]; ay = cy[i];
        end else if (n == 3'd1) begin
          bx = cx[i]; by = cy[i];
        end
        n = n + 3'd1;
      end
    end
    if (vert_r) begin
      seg_nxt = '{segment_valid: vert_ok_r, start_x: xs_r, start_y: 16'sd1,
                  end_x: xs_r, end_y: h_m2};
    end else if (n < 3'd2) begin
      seg_nxt = '{segment_valid: 1'b0, start_x: 16'sd1, start_y: s_r[0],
                  end_x: lim_w, end_y: s_r[1]};
    end else begin
      seg_nxt = '{segment_valid: 1'b1, start_x: ax, start_y: ay, end_x: bx, end_y: by};
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= ev_vld_r;
  end

  assign out_strobe = strobe_r;
  assign out_data   = seg_r;

endmodule

@@ src/scale_and_clip_line_to_frame.sv @@
// ----------------------------------------------------------------------------
// scale_and_clip_line_to_frame
// Scales a line given on a 256 grid to the frame and clips it to the edges.
// A line passes the front pipeline, the queue and the back section before out_strobe.
// Throughput: one line per cycle; busy rises only if the internal queue fills.
// Latency is set by the 17-stage quotient pipelines of the edge divisions.
// Reset (synchronous, rst_n low) clears pipeline valids and the queue and
// loads frame size 1920 x 1080.
// ----------------------------------------------------------------------------
module scale_and_clip_line_to_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sclf_pkg::line_in_t  in_data,
  output logic                out_strobe,
  output sclf_pkg::seg_out_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sclf_pkg::*;

  logic [CW-1:0] frame_width_r, frame_height_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH)  frame_width_r  <= pwdata[CW-1:0];
      if (paddr[2] == REG_HEIGHT) frame_height_r <= pwdata[CW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(frame_height_r) : 32'(frame_width_r);

  logic  acc, front_vld, q_vld, q_full;
  work_t front_data, q_data;

  assign acc  = start && !busy;
  assign busy = q_full;

  sclf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_data(in_data),
    .frame_width(frame_width_r), .frame_height(frame_height_r),
    .out_valid(front_vld), .out_data(front_data)
  );

  sclf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(front_vld), .push_data(front_data),
    .pop(q_vld), .deq_valid(q_vld), .deq_data(q_data), .full(q_full)
  );

  sclf_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(q_vld), .in_data(q_data),
    .frame_width(frame_width_r), .frame_height(frame_height_r),
    .out_strobe(out_strobe), .out_data(out_data)
  );

endmodule

@@ tb/scale_and_clip_line_to_frame_tb.sv @@
// ----------------------------------------------------------------------------
// scale_and_clip_line_to_frame_tb
// Drives line transactions and frame-size register writes into the block and
// checks every segment against a predictor kept in the testbench.
// ----------------------------------------------------------------------------
module scale_and_clip_line_to_frame_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sclf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  line_in_t in_data = '0;
  logic out_strobe;
  seg_out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  longint frame_w = 1920, frame_h = 1080;
  seg_out_t seg_expected[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_enable = 1'b1;

  scale_and_clip_line_to_frame uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint trunc_div(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return num / den;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic seg_out_t clip_segment(line_in_t ln);
    longint x1, y1, x2, y2, dx, dy, p1y, p2y, p3x, p4x;
    longint hx[4], hy[4], ax, ay, bx, by;
    int n;
    logic ok;
    seg_out_t r;
    n = 0;
    x1 = trunc_div(longint'(ln.first_x) * frame_w, 256);
    y1 = trunc_div(longint'(ln.first_y) * frame_h, 256);
    x2 = trunc_div(longint'(ln.second_x) * frame_w, 256);
    y2 = trunc_div(longint'(ln.second_y) * frame_h, 256);
    if (x1 == x2) begin
      ok = (x1 >= 0 && x1 <= frame_w - 1);
      ax = x1; ay = 1; bx = x1; by = frame_h - 2;
    end else begin
      dx = x2 - x1;
      dy = y2 - y1;
      p1y = trunc_div(dy * (1 - x1) + y1 * dx, dx);
      p2y = trunc_div(dy * (frame_w - 1 - x1) + y1 * dx, dx);
      if (p1y >= 0 && p1y <= frame_h - 1) begin
        hx[n] = 1; hy[n] = p1y; n++;
      end
      if (p2y >= 0 && p2y <= frame_h - 1) begin
        hx[n] = frame_w - 1; hy[n] = p2y; n++;
      end
      if (dy != 0) begin
        p3x = trunc_div(dx * (1 - y1) + x1 * dy, dy);
        p4x = trunc_div(dx * (frame_h - 1 - y1) + x1 * dy, dy);
        if (p3x >= 0 && p3x <= frame_w - 1) begin
          hx[n] = p3x; hy[n] = 1; n++;
        end
        if (p4x >= 0 && p4x <= frame_w - 1) begin
          hx[n] = p4x; hy[n] = frame_h - 1; n++;
        end
      end
      if (n < 2) begin
        ok = 1'b0;
        ax = 1; ay = p1y; bx = frame_w - 1; by = p2y;
      end else begin
        ok = 1'b1;
        ax = hx[0]; ay = hy[0]; bx = hx[1]; by = hy[1];
      end
    end
    r.segment_valid = ok;
    r.start_x = clamp16(ax);
    r.start_y = clamp16(ay);
    r.end_x = clamp16(bx);
    r.end_y = clamp16(by);
    return r;
  endfunction

  always @(posedge clk) begin
    seg_out_t e;
    if (rst_n && out_strobe) begin
      if (seg_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %h", out_data);
      end else begin
        e = seg_expected.pop_front();
        if (e !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("segment mismatch: exp %h act %h", e, out_data);
        end
      end
    end
  end

  task automatic idle_gap();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic send_line(line_in_t ln);
    idle_gap();
    start <= 1'b1;
    in_data <= ln;
    @(posedge clk);
    while (busy) @(posedge clk);
    seg_expected.push_back(clip_segment(ln));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (seg_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame(logic [2:0] addr, logic [31:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) frame_w = value & 32'h3fff;
    else frame_h = value & 32'h3fff;
  endtask

  function automatic line_in_t mk(int a, int b, int c, int d);
    line_in_t l;
    l.first_x = 16'(a); l.first_y = 16'(b);
    l.second_x = 16'(c); l.second_y = 16'(d);
    return l;
  endfunction

  function automatic line_in_t rand_line();
    line_in_t l;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      l = mk($urandom_range(0, 300) - 20, $urandom_range(0, 300) - 20,
             $urandom_range(0, 300) - 20, $urandom_range(0, 300) - 20);
      if (k == 0) l.second_x = l.first_x;
      if (k == 1) l.second_y = l.first_y;
    end else l = line_in_t'({$urandom, $urandom});
    return l;
  endfunction

  task automatic test_directed();
    send_line(mk(0, 0, 255, 255));
    send_line(mk(0, 128, 255, 128));
    send_line(mk(100, 0, 100, 255));
    send_line(mk(-32768, -32768, 32767, 32767));
    send_line(mk(32767, -32768, -32768, 32767));
    send_line(mk(-32768, 0, -32768, 100));
    send_line(mk(32767, 5, 32767, 9));
    send_line(mk(0, -32768, 255, -32768));
    send_line(mk(10, 300, 20, 400));
    send_line(mk(255, 0, 0, 255));
    send_line(mk(-1, -1, 1, 1));
    send_line(mk(50, 50, 60, 55));
  endtask

  task automatic test_random(int count);
    repeat (count) send_line(rand_line());
  endtask

  task automatic test_frame_sizes();
    write_frame(3'd0, 32'd8192); write_frame(3'd4, 32'd8192);
    test_directed(); test_random(80);
    write_frame(3'd0, 32'd2); write_frame(3'd4, 32'd3);
    test_directed(); test_random(80);
    write_frame(3'd0, 32'd640); write_frame(3'd4, 32'd480);
    test_random(80);
    write_frame(3'd0, 32'hffff_c000 | $urandom_range(0, 16383));
    write_frame(3'd4, $urandom);
    test_random(40);
    write_frame(3'd0, 32'd1920); write_frame(3'd4, 32'd1080);
    idle_enable = 1'b0;
    test_random(100);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(120);
    test_frame_sizes();
    drain();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

@@ sim.f @@
src/sclf_pkg.sv
src/sclf_front.sv
src/sclf_queue.sv
src/sclf_div.sv
src/sclf_back.sv
src/scale_and_clip_line_to_frame.sv
tb/scale_and_clip_line_to_frame_tb.sv
